[rtl/ssm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ssm_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int DATA_W       = 32;
  localparam int ADDR_W       = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DATA_W-1:0] data_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // store incoming word at the fill position
    logic init_low;    // set up insertion pass over the lower half
    logic init_up;     // set up insertion pass over the upper half
    logic rd_key;      // read element i, j <= i
    logic cap_key;     // key <= read data
    logic rd_prev;     // read element j-1
    logic shift;       // element j <= element j-1, j--
    logic wr_key;      // element j <= key, i++
    logic init_merge;  // heads at start of both runs
    logic rd_a;
    logic cap_a;
    logic rd_b;
    logic cap_b;
    logic emit;        // move picked head to the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic i_lt_hi;
    logic j_gt_lo;
    logic key_lt_prev;
    logic take_a;
    logic last;
    logic out_free;
    logic empty;
  } sts_t;

endpackage

`default_nettype wire

[rtl/ssm_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module ssm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/ssm_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module ssm_datapath (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ssm_pkg::cmd_t         cmd_i,
  output ssm_pkg::sts_t              sts_o,
  input  wire logic [31:0]           value_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic      [31:0]           sorted_value_o,
  output logic                       final_output_o
);

  ssm_pkg::cnt_t  count_q, count_d;
  ssm_pkg::cnt_t  lo_q, lo_d, hi_q, hi_d, i_q, i_d, j_q, j_d;
  ssm_pkg::cnt_t  a_q, a_d, b_q, b_d, k_q, k_d;
  ssm_pkg::data_t key_q, key_d, ha_q, ha_d, hb_q, hb_d;
  ssm_pkg::data_t out_value_q, out_value_d;
  logic           out_final_q, out_final_d;
  logic           out_valid_q, out_valid_d;

  ssm_pkg::cnt_t  mid;
  ssm_pkg::cnt_t  jm1;
  logic           full;
  logic           take_a;
  logic           last;
  logic           out_free;

  logic           ram_we;
  ssm_pkg::addr_t ram_waddr;
  ssm_pkg::data_t ram_wdata;
  logic           ram_re;
  ssm_pkg::addr_t ram_raddr;
  ssm_pkg::data_t ram_rdata;

  assign mid      = count_q >> 1;
  assign jm1      = j_q - ssm_pkg::cnt_t'(1);
  assign full     = (count_q == ssm_pkg::cnt_t'(ssm_pkg::MAX_ELEMENTS));
  // tie goes to the upper run
  assign take_a   = (a_q < mid) &&
                    ((b_q >= count_q) || ($signed(ha_q) < $signed(hb_q)));
  assign last     = ((k_q + ssm_pkg::cnt_t'(1)) == count_q);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o             = '0;
    sts_o.i_lt_hi     = (i_q < hi_q);
    sts_o.j_gt_lo     = (j_q > lo_q);
    sts_o.key_lt_prev = ($signed(key_q) < $signed(ram_rdata));
    sts_o.take_a      = take_a;
    sts_o.last        = last;
    sts_o.out_free    = out_free;
    sts_o.empty       = (count_q == '0);
  end

  // memory port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = j_q[ssm_pkg::ADDR_W-1:0];
    ram_wdata = key_q;
    if (cmd_i.load) begin
      ram_we    = !full;
      ram_waddr = count_q[ssm_pkg::ADDR_W-1:0];
      ram_wdata = value_i;
    end else if (cmd_i.shift) begin
      ram_we    = 1'b1;
      ram_wdata = ram_rdata;
    end else if (cmd_i.wr_key) begin
      ram_we    = 1'b1;
    end

    ram_re    = cmd_i.rd_key || cmd_i.rd_prev || cmd_i.rd_a || cmd_i.rd_b;
    ram_raddr = i_q[ssm_pkg::ADDR_W-1:0];
    if (cmd_i.rd_prev) begin
      ram_raddr = jm1[ssm_pkg::ADDR_W-1:0];
    end else if (cmd_i.rd_a) begin
      ram_raddr = a_q[ssm_pkg::ADDR_W-1:0];
    end else if (cmd_i.rd_b) begin
      ram_raddr = b_q[ssm_pkg::ADDR_W-1:0];
    end
  end

  always_comb begin
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    i_d         = i_q;
    j_d         = j_q;
    a_d         = a_q;
    b_d         = b_q;
    k_d         = k_q;
    key_d       = key_q;
    ha_d        = ha_q;
    hb_d        = hb_q;
    out_value_d = out_value_q;
    out_final_d = out_final_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cmd_i.load && !full) begin
      count_d = count_q + ssm_pkg::cnt_t'(1);
    end
    if (cmd_i.init_low) begin
      lo_d = '0;
      hi_d = mid;
      i_d  = ssm_pkg::cnt_t'(1);
    end
    if (cmd_i.init_up) begin
      lo_d = mid;
      hi_d = count_q;
      i_d  = mid + ssm_pkg::cnt_t'(1);
    end
    if (cmd_i.rd_key) begin
      j_d = i_q;
    end
    if (cmd_i.cap_key) begin
      key_d = ram_rdata;
    end
    if (cmd_i.shift) begin
      j_d = jm1;
    end
    if (cmd_i.wr_key) begin
      i_d = i_q + ssm_pkg::cnt_t'(1);
    end
    if (cmd_i.init_merge) begin
      a_d = '0;
      b_d = mid;
      k_d = '0;
    end
    if (cmd_i.cap_a) begin
      ha_d = ram_rdata;
    end
    if (cmd_i.cap_b) begin
      hb_d = ram_rdata;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_final_d = last;
      k_d         = k_q + ssm_pkg::cnt_t'(1);
      if (take_a) begin
        out_value_d = ha_q;
        a_d         = a_q + ssm_pkg::cnt_t'(1);
      end else begin
        out_value_d = hb_q;
        b_d         = b_q + ssm_pkg::cnt_t'(1);
      end
      if (last) begin
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    i_q         <= i_d;
    j_q         <= j_d;
    a_q         <= a_d;
    b_q         <= b_d;
    k_q         <= k_d;
    key_q       <= key_d;
    ha_q        <= ha_d;
    hb_q        <= hb_d;
    out_value_q <= out_value_d;
    out_final_q <= out_final_d;
  end

  ssm_ram #(
    .WIDTH (ssm_pkg::DATA_W),
    .DEPTH (ssm_pkg::MAX_ELEMENTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_value_q;
  assign final_output_o = out_final_q;

endmodule

`default_nettype wire

[rtl/ssm_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module ssm_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          final_element_i,
  input  wire ssm_pkg::sts_t sts_i,
  output ssm_pkg::cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_INIT_LOW,
    S_INIT_UP,
    S_OUTER,
    S_KEY,
    S_INNER,
    S_CMP,
    S_MERGE,
    S_RD_A0,
    S_RD_B0,
    S_RD_A,
    S_RD_B,
    S_CAP_A,
    S_CAP_B,
    S_PICK
  } state_e;

  state_e state_q, state_d;
  logic   upper_q, upper_d;
  logic   in_ready_q;

  always_comb begin
    state_d = state_q;
    upper_d = upper_q;
    cmd_o   = '0;
    case (state_q)
      S_LOAD: begin
        if (in_valid_i && in_ready_q) begin
          cmd_o.load = 1'b1;
          if (final_element_i) begin
            state_d = S_INIT_LOW;
          end
        end
      end
      S_INIT_LOW: begin
        cmd_o.init_low = 1'b1;
        upper_d        = 1'b0;
        state_d        = S_OUTER;
      end
      S_INIT_UP: begin
        cmd_o.init_up = 1'b1;
        upper_d       = 1'b1;
        state_d       = S_OUTER;
      end
      S_OUTER: begin
        if (sts_i.i_lt_hi) begin
          cmd_o.rd_key = 1'b1;
          state_d      = S_KEY;
        end else if (upper_q) begin
          state_d = S_MERGE;
        end else begin
          state_d = S_INIT_UP;
        end
      end
      S_KEY: begin
        cmd_o.cap_key = 1'b1;
        state_d       = S_INNER;
      end
      S_INNER: begin
        if (sts_i.j_gt_lo) begin
          cmd_o.rd_prev = 1'b1;
          state_d       = S_CMP;
        end else begin
          cmd_o.wr_key = 1'b1;
          state_d      = S_OUTER;
        end
      end
      S_CMP: begin
        if (sts_i.key_lt_prev) begin
          cmd_o.shift = 1'b1;
          state_d     = S_INNER;
        end else begin
          cmd_o.wr_key = 1'b1;
          state_d      = S_OUTER;
        end
      end
      S_MERGE: begin
        cmd_o.init_merge = 1'b1;
        state_d          = S_RD_A0;
      end
      S_RD_A0: begin
        cmd_o.rd_a = 1'b1;
        state_d    = S_RD_B0;
      end
      S_RD_B0: begin
        cmd_o.cap_a = 1'b1;
        cmd_o.rd_b  = 1'b1;
        state_d     = S_CAP_B;
      end
      S_RD_A: begin
        cmd_o.rd_a = 1'b1;
        state_d    = S_CAP_A;
      end
      S_RD_B: begin
        cmd_o.rd_b = 1'b1;
        state_d    = S_CAP_B;
      end
      S_CAP_A: begin
        cmd_o.cap_a = 1'b1;
        state_d     = S_PICK;
      end
      S_CAP_B: begin
        cmd_o.cap_b = 1'b1;
        state_d     = S_PICK;
      end
      S_PICK: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last) begin
            state_d = S_LOAD;
          end else if (sts_i.take_a) begin
            state_d = S_RD_A;
          end else begin
            state_d = S_RD_B;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      upper_q    <= 1'b0;
      in_ready_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      upper_q    <= upper_d;
      in_ready_q <= (state_d == S_LOAD);
    end
  end

  assign in_ready_o = in_ready_q;

endmodule

`default_nettype wire

[rtl/split_sort_merge_sorter_unit.sv]
// Two-way merge sorter for signed 32-bit words. Words are loaded one per cycle
// into a 64-entry RAM until a word marked final_element arrives; words beyond
// 64 are dropped. The block then insertion-sorts the lower half and the upper
// half of the set in place and merges the two runs, emitting every word in
// ascending order with final_output on the last one. The merge holds while the
// output register is still occupied. Sorting and merging are bound by the
// single read port of the element RAM. No input is taken from the final word
// until the last result is in the output register; loading of the next set may
// overlap with that result waiting to be taken.
`timescale 1ns / 1ps
`default_nettype none

module split_sort_merge_sorter_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] value_i,
  input  wire logic        final_element_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [31:0] sorted_value_o,
  output logic             final_output_o
);

  ssm_pkg::cmd_t cmd;
  ssm_pkg::sts_t sts;

  ssm_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .final_element_i (final_element_i),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  ssm_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sorted_value_o (sorted_value_o),
    .final_output_o (final_output_o)
  );

`ifndef ASSERT_OFF
  // one memory write source per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.shift, cmd.wr_key}))
    else $error("conflicting memory writes");

  // a result only enters the output register when it is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("output register overwritten");

  // the last result of a set leaves the store empty for the next set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && sts.last) |=> (sts.empty && in_ready_o))
    else $error("set not cleared after last word");

  // no word is taken while a sort or merge is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.rd_key || cmd.rd_prev || cmd.rd_a || cmd.rd_b) |-> !in_ready_o)
    else $error("input open during sort");
`endif

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    ssm_pkg::data_t word;
    logic           last;
  } word_t;

  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_MOSTLY
  } ready_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] value_i = '0;
  logic        final_element_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] sorted_value_o;
  logic        final_output_o;

  word_t          pending[$];      // words still to be offered
  word_t          sorted_words[$]; // results the block owes us, oldest first
  ssm_pkg::data_t held[$];         // words of the set being loaded
  int             mismatches = 0;
  bit             in_taken = 1'b0;
  int             burst_left = 0;
  int             gap_left = 0;
  ready_mode_e    ready_mode = READY_ALWAYS;
  int             ready_left = 0;

  split_sort_merge_sorter_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .value_i        (value_i),
    .final_element_i(final_element_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sorted_value_o (sorted_value_o),
    .final_output_o (final_output_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic void insert_ascending(ref ssm_pkg::data_t run[$],
                                           input ssm_pkg::data_t w);
    int pos = run.size();
    while (pos > 0 && $signed(w) < $signed(run[pos-1])) pos--;
    run.insert(pos, w);
  endfunction

  // store one word; on the final word sort both halves and merge them
  function automatic void take_word(ssm_pkg::data_t w, logic last);
    ssm_pkg::data_t lo_run[$];
    ssm_pkg::data_t hi_run[$];
    int    half;
    int    total;
    int    a;
    int    b;
    word_t r;
    if (held.size() < ssm_pkg::MAX_ELEMENTS) held.push_back(w);
    if (!last) return;
    total = held.size();
    half  = total / 2;
    for (int k = 0; k < total; k++) begin
      if (k < half) insert_ascending(lo_run, held[k]);
      else insert_ascending(hi_run, held[k]);
    end
    a = 0;
    b = 0;
    for (int k = 0; k < total; k++) begin
      // ties go to the upper run
      if (a < lo_run.size() &&
          (b >= hi_run.size() || $signed(lo_run[a]) < $signed(hi_run[b]))) begin
        r.word = lo_run[a];
        a++;
      end else begin
        r.word = hi_run[b];
        b++;
      end
      r.last = (k == total - 1);
      sorted_words.push_back(r);
    end
    held.delete();
  endfunction

  function automatic void push_word(ssm_pkg::data_t w, logic last);
    word_t it;
    it.word = w;
    it.last = last;
    pending.push_back(it);
  endfunction

  function automatic ssm_pkg::data_t random_word();
    int pick = $urandom_range(0, 9);
    if (pick < 6) return $urandom();
    // narrow range around zero so duplicates show up
    if (pick < 9) begin
      return ssm_pkg::data_t'($urandom_range(0, 16)) - ssm_pkg::data_t'(8);
    end
    return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
  endfunction

  function automatic void push_set(int n);
    for (int k = 0; k < n; k++) push_word(random_word(), k == n - 1);
  endfunction

  // sender: bursts of words with random gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      in_taken = 1'b0;
      if (gap_left > 0 || pending.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i      <= 1'b1;
        value_i         <= pending[0].word;
        final_element_i <= pending[0].last;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // receiver: stall pattern switches between modes at random
  always @(negedge clk_i) begin
    if (ready_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      ready_left = $urandom_range(10, 80);
    end else begin
      ready_left--;
    end
    case (ready_mode)
      READY_ALWAYS: out_ready_i <= 1'b1;
      READY_COIN:   out_ready_i <= $urandom_range(0, 1);
      READY_SPARSE: out_ready_i <= ($urandom_range(0, 5) == 0);
      default:      out_ready_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    word_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        void'(pending.pop_front());
        take_word(value_i, final_element_i);
        in_taken = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        if (sorted_words.size() == 0) begin
          $display("%0t: unexpected word sorted_value %0d final_output %b", $time,
                   $signed(sorted_value_o), final_output_o);
          mismatches++;
        end else begin
          want = sorted_words.pop_front();
          if (sorted_value_o !== want.word) begin
            $display("%0t: sorted_value expected %0d got %0d", $time,
                     $signed(want.word), $signed(sorted_value_o));
            mismatches++;
          end
          if (final_output_o !== want.last) begin
            $display("%0t: final_output expected %b got %b", $time,
                     want.last, final_output_o);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    int random_items;
    int n;
    // single word set at the top of the range
    push_word(32'h7fff_ffff, 1'b1);
    // two words, extremes in reverse order
    push_word(32'h7fff_ffff, 1'b0);
    push_word(32'h8000_0000, 1'b1);
    // duplicates spread over both halves
    push_word(32'h0000_0000, 1'b0);
    push_word(32'hffff_ffff, 1'b0);
    push_word(32'h8000_0000, 1'b0);
    push_word(32'h7fff_ffff, 1'b0);
    push_word(32'hffff_ffff, 1'b0);
    push_word(32'h0000_0000, 1'b1);
    // descending set, crossing zero
    push_word(32'h7fff_fffe, 1'b0);
    push_word(32'd1000, 1'b0);
    push_word(32'd3, 1'b0);
    push_word(32'd1, 1'b0);
    push_word(-32'sd1, 1'b0);
    push_word(-32'sd3, 1'b0);
    push_word(-32'sd1000, 1'b0);
    push_word(32'h8000_0001, 1'b1);
    // all equal
    push_word(32'h5555_aaaa, 1'b0);
    push_word(32'h5555_aaaa, 1'b0);
    push_word(32'h5555_aaaa, 1'b1);

    // overfull set: words past the store size are dropped
    push_set(68);
    random_items = 88;
    while (random_items < 150) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      push_set(n);
      random_items += n;
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    while (pending.size() != 0 || sorted_words.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
